@@ src/qmr_pkg.sv @@
package qmr_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 14;
   localparam int IMM_WIDTH  = DATA_WIDTH + 2;
   localparam int OPD_WIDTH  = DATA_WIDTH + 1;
   localparam int PROD_WIDTH = IMM_WIDTH + OPD_WIDTH;
   localparam int RND_WIDTH  = PROD_WIDTH - FRAC_BITS;
   localparam int SUM_WIDTH  = RND_WIDTH + 2;

   typedef enum logic [1:0] {
      FUNC_MUL  = 2'd0,
      FUNC_ROT  = 2'd1,
      FUNC_MAT  = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [IMM_WIDTH-1:0]  imm_type;
   typedef logic signed [OPD_WIDTH-1:0]  opd_type;
   typedef logic signed [RND_WIDTH-1:0]  rnd_type;
   typedef logic signed [SUM_WIDTH-1:0]  sum_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;

   localparam sum_type DATA_MAX = sum_type'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
   localparam sum_type DATA_MIN = ~DATA_MAX;
   localparam sum_type IMM_MAX  = sum_type'((64'sd1 <<< (IMM_WIDTH - 1)) - 64'sd1);
   localparam sum_type IMM_MIN  = ~IMM_MAX;
   localparam sum_type ONE      = sum_type'(64'sd1 <<< FRAC_BITS);
   localparam prod_type HALF    = prod_type'(64'sd1 <<< (FRAC_BITS - 1));

   typedef struct packed {
      logic [1:0] func;
      data_type   a_w;
      data_type   a_x;
      data_type   a_y;
      data_type   a_z;
      data_type   b_w;
      data_type   b_x;
      data_type   b_y;
      data_type   b_z;
   } qmr_req_type;

   typedef struct packed {
      data_type r0;
      data_type r1;
      data_type r2;
      data_type r3;
      logic     saturated;
      logic     last;
   } qmr_rsp_type;

   // first product done, between front and back halves
   typedef struct packed {
      logic                valid;
      logic [1:0]          func;
      imm_type [3:0]       t;
      logic                sat;
      data_type [8:0]      m;
      logic [2:0]          row_sat;
      data_type [3:0]      a;
   } qmr_mid_type;

   typedef struct packed {
      logic                valid;
      logic [1:0]          func;
      data_type [3:0]      res;
      logic                sat;
      data_type [8:0]      m;
      logic [2:0]          row_sat;
   } qmr_end_type;

   // exact product, add half, floor shift
   function automatic rnd_type round_mul(imm_type p, opd_type q);
      prod_type prod;
      prod = prod_type'(p) * prod_type'(q);
      prod = prod + HALF;
      return rnd_type'(prod >>> FRAC_BITS);
   endfunction

   // msb is the clamp flag
   function automatic logic [DATA_WIDTH:0] sat_data(sum_type v);
      if (v > DATA_MAX) return {1'b1, DATA_MAX[DATA_WIDTH-1:0]};
      if (v < DATA_MIN) return {1'b1, DATA_MIN[DATA_WIDTH-1:0]};
      return {1'b0, v[DATA_WIDTH-1:0]};
   endfunction

   function automatic logic [IMM_WIDTH:0] sat_imm(sum_type v);
      if (v > IMM_MAX) return {1'b1, IMM_MAX[IMM_WIDTH-1:0]};
      if (v < IMM_MIN) return {1'b1, IMM_MIN[IMM_WIDTH-1:0]};
      return {1'b0, v[IMM_WIDTH-1:0]};
   endfunction

endpackage

@@ src/qmr_front.sv @@
module qmr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 hold,
   input  logic                 req_valid,
   input  qmr_pkg::qmr_req_type req,
   output qmr_pkg::qmr_mid_type mid
);

   qmr_pkg::opd_type  av [4];
   qmr_pkg::opd_type  qv [4];
   qmr_pkg::opd_type  tw, tx, ty, tz;
   qmr_pkg::rnd_type  hp_in [16];
   qmr_pkg::rnd_type  hp_ff [16];
   qmr_pkg::rnd_type  mp_in [9];
   qmr_pkg::rnd_type  mp_ff [9];
   logic              b_valid_ff;
   logic [1:0]        b_func_ff;
   qmr_pkg::data_type b_a_ff [4];

   qmr_pkg::sum_type       hs [4];
   qmr_pkg::sum_type       ms [9];
   logic [qmr_pkg::DATA_WIDTH:0] cd [4];
   logic [qmr_pkg::IMM_WIDTH:0]  ci [4];
   logic [qmr_pkg::DATA_WIDTH:0] cm [9];
   qmr_pkg::qmr_mid_type   mid_in;
   qmr_pkg::qmr_mid_type   mid_ff;

   // stage b: all rounded products of a*q and of the matrix terms
   always_comb begin
      av[0] = qmr_pkg::opd_type'(req.a_w);
      av[1] = qmr_pkg::opd_type'(req.a_x);
      av[2] = qmr_pkg::opd_type'(req.a_y);
      av[3] = qmr_pkg::opd_type'(req.a_z);
      qv[0] = (req.func == qmr_pkg::FUNC_ROT) ? '0 : qmr_pkg::opd_type'(req.b_w);
      qv[1] = qmr_pkg::opd_type'(req.b_x);
      qv[2] = qmr_pkg::opd_type'(req.b_y);
      qv[3] = qmr_pkg::opd_type'(req.b_z);
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            hp_in[i*4+j] = qmr_pkg::round_mul(qmr_pkg::imm_type'(av[i]), qv[j]);
         end
      end
      tw = {req.a_w, 1'b0};
      tx = {req.a_x, 1'b0};
      ty = {req.a_y, 1'b0};
      tz = {req.a_z, 1'b0};
      mp_in[0] = qmr_pkg::round_mul(qmr_pkg::imm_type'(ty), av[2]);
      mp_in[1] = qmr_pkg::round_mul(qmr_pkg::imm_type'(tz), av[3]);
      mp_in[2] = qmr_pkg::round_mul(qmr_pkg::imm_type'(tx), av[2]);
      mp_in[3] = qmr_pkg::round_mul(qmr_pkg::imm_type'(tw), av[3]);
      mp_in[4] = qmr_pkg::round_mul(qmr_pkg::imm_type'(tx), av[3]);
      mp_in[5] = qmr_pkg::round_mul(qmr_pkg::imm_type'(tw), av[2]);
      mp_in[6] = qmr_pkg::round_mul(qmr_pkg::imm_type'(tx), av[1]);
      mp_in[7] = qmr_pkg::round_mul(qmr_pkg::imm_type'(ty), av[3]);
      mp_in[8] = qmr_pkg::round_mul(qmr_pkg::imm_type'(tw), av[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (!hold) begin
         b_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         b_func_ff <= req.func;
         hp_ff     <= hp_in;
         mp_ff     <= mp_in;
         b_a_ff[0] <= req.a_w;
         b_a_ff[1] <= req.a_x;
         b_a_ff[2] <= req.a_y;
         b_a_ff[3] <= req.a_z;
      end
   end

   // stage c: sums and clamps
   always_comb begin
      hs[0] = qmr_pkg::sum_type'(hp_ff[0]) - qmr_pkg::sum_type'(hp_ff[5])
            - qmr_pkg::sum_type'(hp_ff[10]) - qmr_pkg::sum_type'(hp_ff[15]);
      hs[1] = qmr_pkg::sum_type'(hp_ff[1]) + qmr_pkg::sum_type'(hp_ff[4])
            + qmr_pkg::sum_type'(hp_ff[11]) - qmr_pkg::sum_type'(hp_ff[14]);
      hs[2] = qmr_pkg::sum_type'(hp_ff[2]) - qmr_pkg::sum_type'(hp_ff[7])
            + qmr_pkg::sum_type'(hp_ff[8]) + qmr_pkg::sum_type'(hp_ff[13]);
      hs[3] = qmr_pkg::sum_type'(hp_ff[3]) + qmr_pkg::sum_type'(hp_ff[6])
            - qmr_pkg::sum_type'(hp_ff[9]) + qmr_pkg::sum_type'(hp_ff[12]);

      ms[0] = qmr_pkg::ONE - qmr_pkg::sum_type'(mp_ff[0]) - qmr_pkg::sum_type'(mp_ff[1]);
      ms[1] = qmr_pkg::sum_type'(mp_ff[2]) - qmr_pkg::sum_type'(mp_ff[3]);
      ms[2] = qmr_pkg::sum_type'(mp_ff[4]) + qmr_pkg::sum_type'(mp_ff[5]);
      ms[3] = qmr_pkg::sum_type'(mp_ff[2]) + qmr_pkg::sum_type'(mp_ff[3]);
      ms[4] = qmr_pkg::ONE - qmr_pkg::sum_type'(mp_ff[6]) - qmr_pkg::sum_type'(mp_ff[1]);
      ms[5] = qmr_pkg::sum_type'(mp_ff[7]) + qmr_pkg::sum_type'(mp_ff[8]);
      ms[6] = qmr_pkg::sum_type'(mp_ff[4]) - qmr_pkg::sum_type'(mp_ff[5]);
      ms[7] = qmr_pkg::sum_type'(mp_ff[7]) - qmr_pkg::sum_type'(mp_ff[8]);
      ms[8] = qmr_pkg::ONE - qmr_pkg::sum_type'(mp_ff[6]) - qmr_pkg::sum_type'(mp_ff[0]);

      mid_in.valid = b_valid_ff;
      mid_in.func  = b_func_ff;
      mid_in.sat   = 1'b0;
      for (int k = 0; k < 4; k++) begin
         cd[k] = qmr_pkg::sat_data(hs[k]);
         ci[k] = qmr_pkg::sat_imm(hs[k]);
         mid_in.a[k] = b_a_ff[k];
         if (b_func_ff == qmr_pkg::FUNC_ROT) begin
            mid_in.t[k] = ci[k][qmr_pkg::IMM_WIDTH-1:0];
            mid_in.sat  = mid_in.sat | ci[k][qmr_pkg::IMM_WIDTH];
         end else begin
            mid_in.t[k] = qmr_pkg::imm_type'($signed(cd[k][qmr_pkg::DATA_WIDTH-1:0]));
            mid_in.sat  = mid_in.sat | cd[k][qmr_pkg::DATA_WIDTH];
         end
      end
      mid_in.row_sat = '0;
      for (int k = 0; k < 9; k++) begin
         cm[k] = qmr_pkg::sat_data(ms[k]);
         mid_in.m[k] = cm[k][qmr_pkg::DATA_WIDTH-1:0];
         mid_in.row_sat[k/3] = mid_in.row_sat[k/3] | cm[k][qmr_pkg::DATA_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff.valid <= 1'b0;
      end else if (!hold) begin
         mid_ff <= mid_in;
      end
   end

   assign mid = mid_ff;

endmodule

@@ src/qmr_back.sv @@
module qmr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 hold,
   input  qmr_pkg::qmr_mid_type mid,
   output qmr_pkg::qmr_end_type fin
);

   qmr_pkg::imm_type  tv [4];
   qmr_pkg::opd_type  cv [4];
   qmr_pkg::rnd_type  pr_in [12];
   qmr_pkg::rnd_type  pr_ff [12];
   logic              d_valid_ff;
   logic [1:0]        d_func_ff;
   qmr_pkg::imm_type  d_t_ff [4];
   logic              d_sat_ff;
   qmr_pkg::data_type d_m_ff [9];
   logic [2:0]        d_row_sat_ff;

   qmr_pkg::sum_type             rs [3];
   logic [qmr_pkg::DATA_WIDTH:0] cr [3];
   qmr_pkg::qmr_end_type         fin_in;
   qmr_pkg::qmr_end_type         fin_ff;

   // stage d: products of the intermediate with conj(a)
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         tv[k] = mid.t[k];
      end
      cv[0] = qmr_pkg::opd_type'(mid.a[0]);
      cv[1] = -qmr_pkg::opd_type'(mid.a[1]);
      cv[2] = -qmr_pkg::opd_type'(mid.a[2]);
      cv[3] = -qmr_pkg::opd_type'(mid.a[3]);
      pr_in[0]  = qmr_pkg::round_mul(tv[0], cv[1]);
      pr_in[1]  = qmr_pkg::round_mul(tv[1], cv[0]);
      pr_in[2]  = qmr_pkg::round_mul(tv[2], cv[3]);
      pr_in[3]  = qmr_pkg::round_mul(tv[3], cv[2]);
      pr_in[4]  = qmr_pkg::round_mul(tv[0], cv[2]);
      pr_in[5]  = qmr_pkg::round_mul(tv[1], cv[3]);
      pr_in[6]  = qmr_pkg::round_mul(tv[2], cv[0]);
      pr_in[7]  = qmr_pkg::round_mul(tv[3], cv[1]);
      pr_in[8]  = qmr_pkg::round_mul(tv[0], cv[3]);
      pr_in[9]  = qmr_pkg::round_mul(tv[1], cv[2]);
      pr_in[10] = qmr_pkg::round_mul(tv[2], cv[1]);
      pr_in[11] = qmr_pkg::round_mul(tv[3], cv[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (!hold) begin
         d_valid_ff <= mid.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         d_func_ff    <= mid.func;
         pr_ff        <= pr_in;
         d_t_ff       <= tv;
         d_sat_ff     <= mid.sat;
         d_row_sat_ff <= mid.row_sat;
         for (int k = 0; k < 9; k++) begin
            d_m_ff[k] <= mid.m[k];
         end
      end
   end

   // stage e: rotated vector sums, clamp and result select
   always_comb begin
      rs[0] = qmr_pkg::sum_type'(pr_ff[0]) + qmr_pkg::sum_type'(pr_ff[1])
            + qmr_pkg::sum_type'(pr_ff[2]) - qmr_pkg::sum_type'(pr_ff[3]);
      rs[1] = qmr_pkg::sum_type'(pr_ff[4]) - qmr_pkg::sum_type'(pr_ff[5])
            + qmr_pkg::sum_type'(pr_ff[6]) + qmr_pkg::sum_type'(pr_ff[7]);
      rs[2] = qmr_pkg::sum_type'(pr_ff[8]) + qmr_pkg::sum_type'(pr_ff[9])
            - qmr_pkg::sum_type'(pr_ff[10]) + qmr_pkg::sum_type'(pr_ff[11]);

      fin_in.valid   = d_valid_ff;
      fin_in.func    = d_func_ff;
      fin_in.row_sat = d_row_sat_ff;
      for (int k = 0; k < 9; k++) begin
         fin_in.m[k] = d_m_ff[k];
      end
      fin_in.sat = d_sat_ff;
      for (int k = 0; k < 3; k++) begin
         cr[k] = qmr_pkg::sat_data(rs[k]);
      end
      if (d_func_ff == qmr_pkg::FUNC_ROT) begin
         for (int k = 0; k < 3; k++) begin
            fin_in.res[k] = cr[k][qmr_pkg::DATA_WIDTH-1:0];
            fin_in.sat    = fin_in.sat | cr[k][qmr_pkg::DATA_WIDTH];
         end
         fin_in.res[3] = '0;
      end else begin
         for (int k = 0; k < 4; k++) begin
            fin_in.res[k] = d_t_ff[k][qmr_pkg::DATA_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff.valid <= 1'b0;
      end else if (!hold) begin
         fin_ff <= fin_in;
      end
   end

   assign fin = fin_ff;

endmodule

@@ src/qmr_emit.sv @@
module qmr_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  qmr_pkg::qmr_end_type fin,
   output logic                 hold,
   output logic                 rsp_valid,
   output qmr_pkg::qmr_rsp_type rsp
);

   localparam logic [1:0] LAST_ROW = 2'd2;

   logic                 is_mat;
   logic [1:0]           row_ff;
   logic [1:0]           row_in;
   logic                 rsp_valid_ff;
   qmr_pkg::qmr_rsp_type rsp_ff;
   qmr_pkg::qmr_rsp_type rsp_in;

   // a matrix request holds the pipe while its first two rows go out
   always_comb begin
      is_mat = fin.valid && (fin.func == qmr_pkg::FUNC_MAT);
      hold   = is_mat && (row_ff != LAST_ROW);
      row_in = hold ? row_ff + 2'd1 : 2'd0;
   end

   always_comb begin
      if (is_mat) begin
         case (row_ff)
            2'd0: begin
               rsp_in.r0 = fin.m[0];
               rsp_in.r1 = fin.m[1];
               rsp_in.r2 = fin.m[2];
            end
            2'd1: begin
               rsp_in.r0 = fin.m[3];
               rsp_in.r1 = fin.m[4];
               rsp_in.r2 = fin.m[5];
            end
            default: begin
               rsp_in.r0 = fin.m[6];
               rsp_in.r1 = fin.m[7];
               rsp_in.r2 = fin.m[8];
            end
         endcase
         rsp_in.r3        = '0;
         rsp_in.saturated = (row_ff == 2'd0) ? fin.row_sat[0] :
                            (row_ff == 2'd1) ? fin.row_sat[1] : fin.row_sat[2];
         rsp_in.last      = (row_ff == LAST_ROW);
      end else begin
         rsp_in.r0        = fin.res[0];
         rsp_in.r1        = fin.res[1];
         rsp_in.r2        = fin.res[2];
         rsp_in.r3        = fin.res[3];
         rsp_in.saturated = fin.sat;
         rsp_in.last      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         rsp_valid_ff <= fin.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef NO_ASSERTIONS
   a_hold_only_mat: assert property (@(posedge clock) disable iff (reset)
      hold |-> (fin.valid && fin.func == qmr_pkg::FUNC_MAT))
      else $error("hold without a matrix request");
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff != 2'd3)
      else $error("row counter out of range");
   a_row_idle: assert property (@(posedge clock) disable iff (reset)
      !is_mat |-> row_ff == 2'd0)
      else $error("row counter busy without a matrix request");
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      (is_mat && row_ff == LAST_ROW) |=> (rsp_valid && rsp.last))
      else $error("final matrix row not marked last");
   a_no_unknown: assert property (@(posedge clock) disable iff (reset)
      fin.valid |-> fin.func != qmr_pkg::FUNC_NONE)
      else $error("unknown operation in the pipe");
`endif

endmodule

@@ src/quaternion_multiply_rotate_unit_top.sv @@
// quaternion unit, signed Q2.14 operands and results
// request side: a request is taken at a clock edge where start is high and
// busy is low; req_data carries func and quaternions a and b
// result side: rsp_valid marks a result on rsp_data for exactly one cycle;
// the receiver cannot stall, every result must be taken as it comes
// multiply and rotate give one result; rotation matrix gives three rows on
// consecutive cycles, last set on the third
// a request passes through the input register, product bank, sum/clamp,
// conj product bank, sum/clamp, then the output register
// throughput: one request per cycle for multiply and rotate while busy is low;
// a matrix request holds busy while its first two rows are emitted, since the
// output register sends one row per cycle
// unknown func codes are accepted and produce no result
// reset clears all valid bits and the row counter; nothing is in flight
// afterward and busy is low
module quaternion_multiply_rotate_unit_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  qmr_pkg::qmr_req_type req_data,
   output logic                 rsp_valid,
   output qmr_pkg::qmr_rsp_type rsp_data
);

   logic                 hold;
   logic                 req_valid_ff;
   logic                 req_valid_in;
   qmr_pkg::qmr_req_type req_ff;
   qmr_pkg::qmr_mid_type mid;
   qmr_pkg::qmr_end_type fin;

   assign busy         = hold;
   assign req_valid_in = start && (req_data.func != qmr_pkg::FUNC_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!hold) begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         req_ff <= req_data;
      end
   end

   qmr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .hold      (hold),
      .req_valid (req_valid_ff),
      .req       (req_ff),
      .mid       (mid)
   );

   qmr_back u_back (
      .clock (clock),
      .reset (reset),
      .hold  (hold),
      .mid   (mid),
      .fin   (fin)
   );

   qmr_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .fin       (fin),
      .hold      (hold),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule

@@ tb/tb_quaternion_multiply_rotate_unit_top.sv @@
`timescale 1ns / 100ps

module tb_quaternion_multiply_rotate_unit_top;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   qmr_pkg::qmr_req_type req_data;
   logic                 rsp_valid;
   qmr_pkg::qmr_rsp_type rsp_data;

   qmr_pkg::qmr_rsp_type pending_rows[$];
   int                   error_count;
   int                   idle_pct;

   quaternion_multiply_rotate_unit_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   // exact product, add half, floor shift by the fraction width
   function automatic longint rmul(longint p, longint q);
      longint prod;
      prod = p * q + (longint'(1) <<< (qmr_pkg::FRAC_BITS - 1));
      return prod >>> qmr_pkg::FRAC_BITS;
   endfunction

   function automatic longint clip(longint v, int w, ref logic flag);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -(longint'(1) <<< (w - 1));
      if (v > hi) begin
         flag = 1'b1;
         return hi;
      end
      if (v < lo) begin
         flag = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic void hamilton(input longint p[4], input longint q[4],
                                    output longint r[4]);
      r[0] = rmul(p[0], q[0]) - rmul(p[1], q[1]) - rmul(p[2], q[2]) - rmul(p[3], q[3]);
      r[1] = rmul(p[0], q[1]) + rmul(p[1], q[0]) + rmul(p[2], q[3]) - rmul(p[3], q[2]);
      r[2] = rmul(p[0], q[2]) - rmul(p[1], q[3]) + rmul(p[2], q[0]) + rmul(p[3], q[1]);
      r[3] = rmul(p[0], q[3]) + rmul(p[1], q[2]) - rmul(p[2], q[1]) + rmul(p[3], q[0]);
   endfunction

   function automatic void predict_quaternion(qmr_pkg::qmr_req_type rq);
      longint a[4], b[4], v[4], t[4], c[4], r[4], m[9], one;
      longint w, x, y, z;
      logic sat;
      qmr_pkg::qmr_rsp_type row;
      a[0] = rq.a_w; a[1] = rq.a_x; a[2] = rq.a_y; a[3] = rq.a_z;
      b[0] = rq.b_w; b[1] = rq.b_x; b[2] = rq.b_y; b[3] = rq.b_z;
      one = longint'(1) <<< qmr_pkg::FRAC_BITS;
      sat = 1'b0;
      row = '0;
      case (qmr_pkg::func_type'(rq.func))
         qmr_pkg::FUNC_MUL: begin
            hamilton(a, b, r);
            row.r0 = qmr_pkg::data_type'(clip(r[0], qmr_pkg::DATA_WIDTH, sat));
            row.r1 = qmr_pkg::data_type'(clip(r[1], qmr_pkg::DATA_WIDTH, sat));
            row.r2 = qmr_pkg::data_type'(clip(r[2], qmr_pkg::DATA_WIDTH, sat));
            row.r3 = qmr_pkg::data_type'(clip(r[3], qmr_pkg::DATA_WIDTH, sat));
            row.saturated = sat;
            row.last = 1'b1;
            pending_rows.push_back(row);
         end
         qmr_pkg::FUNC_ROT: begin
            v[0] = 0; v[1] = b[1]; v[2] = b[2]; v[3] = b[3];
            hamilton(a, v, t);
            for (int j = 0; j < 4; j++) t[j] = clip(t[j], qmr_pkg::IMM_WIDTH, sat);
            c[0] = a[0]; c[1] = -a[1]; c[2] = -a[2]; c[3] = -a[3];
            hamilton(t, c, r);
            row.r0 = qmr_pkg::data_type'(clip(r[1], qmr_pkg::DATA_WIDTH, sat));
            row.r1 = qmr_pkg::data_type'(clip(r[2], qmr_pkg::DATA_WIDTH, sat));
            row.r2 = qmr_pkg::data_type'(clip(r[3], qmr_pkg::DATA_WIDTH, sat));
            row.saturated = sat;
            row.last = 1'b1;
            pending_rows.push_back(row);
         end
         qmr_pkg::FUNC_MAT: begin
            w = a[0]; x = a[1]; y = a[2]; z = a[3];
            m[0] = one - rmul(2 * y, y) - rmul(2 * z, z);
            m[1] = rmul(2 * x, y) - rmul(2 * w, z);
            m[2] = rmul(2 * x, z) + rmul(2 * w, y);
            m[3] = rmul(2 * x, y) + rmul(2 * w, z);
            m[4] = one - rmul(2 * x, x) - rmul(2 * z, z);
            m[5] = rmul(2 * y, z) + rmul(2 * w, x);
            m[6] = rmul(2 * x, z) - rmul(2 * w, y);
            m[7] = rmul(2 * y, z) - rmul(2 * w, x);
            m[8] = one - rmul(2 * x, x) - rmul(2 * y, y);
            for (int k = 0; k < 3; k++) begin
               sat = 1'b0;
               row = '0;
               row.r0 = qmr_pkg::data_type'(clip(m[3 * k], qmr_pkg::DATA_WIDTH, sat));
               row.r1 = qmr_pkg::data_type'(clip(m[3 * k + 1], qmr_pkg::DATA_WIDTH, sat));
               row.r2 = qmr_pkg::data_type'(clip(m[3 * k + 2], qmr_pkg::DATA_WIDTH, sat));
               row.saturated = sat;
               row.last = (k == 2);
               pending_rows.push_back(row);
            end
         end
         default: ;
      endcase
   endfunction

   // result checker
   initial begin
      qmr_pkg::qmr_rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1) begin
            if (pending_rows.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               error_count++;
            end else begin
               want = pending_rows.pop_front();
               if (rsp_data.r0 !== want.r0 || rsp_data.r1 !== want.r1 ||
                   rsp_data.r2 !== want.r2 || rsp_data.r3 !== want.r3 ||
                   rsp_data.saturated !== want.saturated ||
                   rsp_data.last !== want.last) begin
                  $display("%0t: mismatch expected r=%0d %0d %0d %0d sat=%b last=%b",
                           $time, want.r0, want.r1, want.r2, want.r3,
                           want.saturated, want.last);
                  $display("%0t:          actual r=%0d %0d %0d %0d sat=%b last=%b",
                           $time, rsp_data.r0, rsp_data.r1, rsp_data.r2,
                           rsp_data.r3, rsp_data.saturated, rsp_data.last);
                  error_count++;
               end
            end
         end
      end
   end

   // drive one request, holding start until busy is low at a rising edge
   task automatic send_request(qmr_pkg::qmr_req_type rq);
      logic taken;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= rq;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = (busy === 1'b0);
         @(negedge clock);
      end
      predict_quaternion(rq);
   endtask

   function automatic qmr_pkg::data_type pick_value();
      case ($urandom_range(9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh4000;
         3: return 16'shc000;
         4: return 16'sh0000;
         default: return qmr_pkg::data_type'($urandom);
      endcase
   endfunction

   function automatic qmr_pkg::qmr_req_type random_request();
      qmr_pkg::qmr_req_type rq;
      rq = qmr_pkg::qmr_req_type'($bits(qmr_pkg::qmr_req_type)'(
              {$urandom, $urandom, $urandom, $urandom, $urandom}));
      rq.func = ($urandom_range(15) == 0) ? qmr_pkg::FUNC_NONE : 2'($urandom_range(2));
      case ($urandom_range(2))
         // unit-ish values in Q2.14
         0: begin
            rq.a_w = qmr_pkg::data_type'($signed(17'($urandom_range(32767))) - 17'sd16384);
            rq.a_x = qmr_pkg::data_type'($signed(17'($urandom_range(32767))) - 17'sd16384);
            rq.a_y = qmr_pkg::data_type'($signed(17'($urandom_range(32767))) - 17'sd16384);
            rq.a_z = qmr_pkg::data_type'($signed(17'($urandom_range(32767))) - 17'sd16384);
         end
         1: begin
            rq.a_w = pick_value(); rq.a_x = pick_value();
            rq.a_y = pick_value(); rq.a_z = pick_value();
            rq.b_w = pick_value(); rq.b_x = pick_value();
            rq.b_y = pick_value(); rq.b_z = pick_value();
         end
         default: ;
      endcase
      return rq;
   endfunction

   task automatic drain_results();
      start <= 1'b0;
      @(negedge clock);
      while (pending_rows.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      qmr_pkg::qmr_req_type rq;
      qmr_pkg::data_type edge_vals[5];
      edge_vals = '{16'sh7fff, 16'sh8000, 16'sh4000, 16'sh0000, 16'shffff};
      idle_pct = 0;
      for (int f = 0; f < 4; f++) begin
         // identity, then operands drawn from the edge values
         rq = '0;
         rq.func = 2'(f);
         rq.a_w = 16'sh4000;
         rq.b_x = 16'sh4000; rq.b_y = 16'sh2000; rq.b_z = -16'sh1000;
         rq.b_w = 16'sh1234;
         send_request(rq);
         for (int e = 0; e < 5; e++) begin
            rq.a_w = edge_vals[e]; rq.a_x = edge_vals[e];
            rq.a_y = edge_vals[(e + 1) % 5]; rq.a_z = edge_vals[(e + 2) % 5];
            rq.b_w = edge_vals[(e + 3) % 5]; rq.b_x = edge_vals[e];
            rq.b_y = edge_vals[(e + 4) % 5]; rq.b_z = edge_vals[e];
            send_request(rq);
         end
      end
      drain_results();
   endtask

   task automatic test_random_phase(int pct, int count);
      idle_pct = pct;
      for (int i = 0; i < count; i++) send_request(random_request());
   endtask

   task automatic test_pause_until_drained();
      idle_pct = 0;
      for (int i = 0; i < 10; i++) send_request(random_request());
      // sender holds off until the pipeline is empty
      drain_results();
      repeat (8) @(negedge clock);
      for (int i = 0; i < 10; i++) send_request(random_request());
   endtask

   initial begin
      int guard;
      error_count = 0;
      idle_pct    = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random_phase(0, 100);
      test_random_phase(52, 100);
      test_random_phase(11, 90);
      test_pause_until_drained();
      test_random_phase(0, 76);
      start <= 1'b0;
      guard = 0;
      while (pending_rows.size() != 0 && guard < 1000) begin
         @(negedge clock);
         guard++;
      end
      repeat (10) @(negedge clock);
      if (error_count == 0 && pending_rows.size() == 0) begin
         $display("PASS");
      end else begin
         if (pending_rows.size() != 0)
            $display("%0t: %0d results never arrived", $time, pending_rows.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule
